[src/mkd_pkg.sv]
`timescale 1ns / 1ps

package mkd_pkg;

    // packed code: bits 7..5 element count, bits 4..0 elements (1 dash)
    localparam int CODE_W   = 8;
    localparam int CHAR_W   = 7;
    localparam int UNIT_W   = 12;
    localparam int TABLE_N  = 35;
    localparam int LETTER_N = 26;
    localparam int MAX_ELEM = 5;

    localparam logic [UNIT_W-1:0] UNIT_RESET   = 12'd100;
    localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'd63;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'd10;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;

    // letters a..z, then digits 0..8
    localparam logic [CODE_W-1:0] CODE_TABLE [TABLE_N] = '{
        8'h48, 8'h90, 8'h94, 8'h70, 8'h20, 8'h84, 8'h78, 8'h80, 8'h40, 8'h8e,
        8'h74, 8'h88, 8'h58, 8'h50, 8'h7c, 8'h8c, 8'h9a, 8'h68, 8'h60, 8'h30,
        8'h64, 8'h82, 8'h6c, 8'h92, 8'h96, 8'h98, 8'hbf, 8'haf, 8'ha7, 8'ha3,
        8'ha1, 8'ha0, 8'hb0, 8'hb8, 8'hbc
    };

    // code leaving the timing stage toward the output register
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } mkd_result_t;

endpackage

[src/morse_key_decoder_core.sv]
`timescale 1ns / 1ps
// path: a key sample sits in the input register from its accepting edge; its result, if
// any, enters the output word register as the sample advances and shows on the m_ side
// throughput: one sample per cycle (single timing and packing stage) unless m_ stalls
// reset: synchronous on aresetn low; time_unit returns to 100, key taken as released,
// code and tick count cleared, both channels empty

module morse_key_decoder_core
    import mkd_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [0] key_level
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [6:0] char_out, [14:7] code_word
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [UNIT_W-1:0] cfg_data
);

    logic              in_valid_reg, in_level_reg;
    logic              m_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [CODE_W-1:0] code_reg;
    logic              advance;
    mkd_result_t       result;
    logic [CHAR_W-1:0] char_dec;

    // handshakes: input stage moves on when the output register is free or draining
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    mkd_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_valid && cfg_ready),
        .cfg_unit(cfg_data),
        .step_en (advance),
        .level   (in_level_reg),
        .result  (result)
    );

    mkd_decode u_decode (
        .code    (result.code),
        .char_out(char_dec)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_level_reg <= s_tdata[0];
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (result.valid) begin
            char_reg <= char_dec;
            code_reg <= result.code;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, code_reg, char_reg};

`ifndef ASSERT_OFF
    a_newline_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && char_reg == CHAR_NEWLINE) |-> (code_reg == '0))
        else $error("newline word carries a nonzero code");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_level_reg)))
        else $error("stalled sample lost or changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !in_valid_reg))
        else $error("channels not empty after reset");
`endif

endmodule

[src/mkd_decode.sv]
`timescale 1ns / 1ps

module mkd_decode
    import mkd_pkg::*;
(
    input  logic [CODE_W-1:0] code,
    output logic [CHAR_W-1:0] char_out
);

    // parallel match against the code table, first hit wins
    always_comb begin
        logic hit;
        hit = 1'b0;
        char_out = CHAR_UNKNOWN;
        if (code == '0) begin
            char_out = CHAR_NEWLINE;
        end else begin
            for (int i = 0; i < TABLE_N; i++) begin
                if (!hit && CODE_TABLE[i] == code) begin
                    hit = 1'b1;
                    if (i < LETTER_N) begin
                        char_out = CHAR_LOWER_A + CHAR_W'(i);
                    end else begin
                        char_out = CHAR_ZERO + CHAR_W'(i - LETTER_N);
                    end
                end
            end
        end
    end

endmodule

[src/mkd_step.sv]
`timescale 1ns / 1ps

module mkd_step
    import mkd_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [UNIT_W-1:0] cfg_unit,
    input  logic              step_en,
    input  logic              level,
    output mkd_result_t       result
);

    localparam int CMP_W = COUNT_WIDTH + 4;

    typedef enum logic [1:0] {
        PH_CHAR  = 2'd0,
        PH_AFTER = 2'd1,
        PH_IDLE  = 2'd2
    } phase_t;

    logic [UNIT_W-1:0]      unit_reg;
    logic [COUNT_WIDTH-1:0] elapsed_reg, elapsed_next;
    phase_t                 phase_reg, phase_next;
    logic [CODE_W-1:0]      code_reg, code_next;
    logic                   prev_reg;

    logic [COUNT_WIDTH-1:0] inc;
    logic [CMP_W-1:0]       inc_x, two_u, six_u;
    logic                   changed, fire_word, fire_char, dash;
    logic [2:0]             len, len_eff;
    logic [4:0]             elems;

    // saturating tick count and the two gap thresholds
    assign inc     = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + COUNT_WIDTH'(1);
    assign inc_x   = CMP_W'(inc);
    assign two_u   = CMP_W'({unit_reg, 1'b0});
    assign six_u   = CMP_W'({unit_reg, 2'b00}) + two_u;
    assign changed = (level != prev_reg);

    assign fire_word = (phase_reg == PH_AFTER) && (inc_x > six_u);
    assign fire_char = (phase_reg == PH_CHAR) && (inc_x > two_u);

    // element packing on release
    assign len     = code_reg[7:5];
    assign len_eff = (len >= 3'(MAX_ELEM)) ? 3'd0 : len;
    assign dash    = (inc_x >= two_u);
    assign elems   = ((len >= 3'(MAX_ELEM)) ? 5'd0 : code_reg[4:0])
                   | (5'(dash) << (3'd4 - len_eff));

    // next state and emitted code
    always_comb begin
        elapsed_next = changed ? '0 : inc;
        phase_next   = phase_reg;
        code_next    = code_reg;
        result.valid = 1'b0;
        result.code  = code_reg;
        if (changed && level) begin
            phase_next   = PH_CHAR;
            result.valid = (len >= 3'(MAX_ELEM));
            code_next    = {len_eff + 3'd1, elems};
        end else if (changed || level) begin
            if (fire_word || fire_char) begin
                result.valid = 1'b1;
                code_next    = '0;
            end
            if (changed) begin
                phase_next = PH_IDLE;
            end else if (fire_word) begin
                phase_next = PH_IDLE;
            end else if (fire_char) begin
                phase_next = PH_AFTER;
            end
        end
        result.valid = result.valid & step_en;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg    <= UNIT_RESET;
            elapsed_reg <= '0;
            phase_reg   <= PH_IDLE;
            code_reg    <= '0;
            prev_reg    <= 1'b1;
        end else begin
            if (cfg_we) begin
                unit_reg <= cfg_unit;
            end
            if (step_en) begin
                elapsed_reg <= elapsed_next;
                phase_reg   <= phase_next;
                code_reg    <= code_next;
                prev_reg    <= level;
            end
        end
    end

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> (result.code[7:5] <= 3'(MAX_ELEM)))
        else $error("emitted code holds more than five elements");

    a_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && changed) |=> (elapsed_reg == '0))
        else $error("tick count not cleared on level change");

    a_release_pack: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && changed && level) |=> (phase_reg == PH_CHAR && code_reg[7:5] != 3'd0))
        else $error("release did not start a character");
`endif

endmodule
